// File: rtl/pid_controller_pos_incr_core_assert.svh
// Assertion helpers used by the core RTL file. Each macro expects signals
// named clock and reset in the scope where it is used.
`ifndef PID_CONTROLLER_POS_INCR_CORE_ASSERT_SVH
`define PID_CONTROLLER_POS_INCR_CORE_ASSERT_SVH

// Same-cycle implication.
`define PIDPI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PIDPI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pidpi_pkg.sv
package pidpi_pkg;

   localparam int unsigned SampleWidth  = 16;
   localparam int unsigned ErrWidth     = 17;
   localparam int unsigned GainWidth    = 16;
   localparam int unsigned LimitWidth   = 24;
   localparam int unsigned IntegWidth   = 26;
   localparam int unsigned DriveWidth   = 16;
   localparam int unsigned OperandWidth = 26;
   localparam int unsigned ProductWidth = GainWidth + 1 + OperandWidth;
   localparam int unsigned AccWidth     = 40;
   localparam int unsigned QShift       = 8;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 24;

   localparam logic [CsrIndexWidth-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DRIVE_MIN      = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_DRIVE_MAX      = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_INTEGRAL_LIMIT = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_LOOP_FORM      = 3'd6;

   localparam logic FORM_POSITIONAL  = 1'b0;
   localparam logic FORM_INCREMENTAL = 1'b1;

   localparam logic [GainWidth-1:0]         GainPReset     = 16'd256;
   localparam logic [GainWidth-1:0]         GainIReset     = 16'd0;
   localparam logic [GainWidth-1:0]         GainDReset     = 16'd0;
   localparam logic signed [DriveWidth-1:0] DriveMinReset  = -16'sd32768;
   localparam logic signed [DriveWidth-1:0] DriveMaxReset  = 16'sd32767;
   localparam logic [LimitWidth-1:0]        IntegLimReset  = 24'd1048576;

   typedef struct packed {
      logic [GainWidth-1:0]         gain_p;
      logic [GainWidth-1:0]         gain_i;
      logic [GainWidth-1:0]         gain_d;
      logic signed [DriveWidth-1:0] drive_min;
      logic signed [DriveWidth-1:0] drive_max;
      logic [LimitWidth-1:0]        integral_limit;
      logic                         loop_form;
   } cfg_type;

   // Gain times operand, then an arithmetic shift, which floors the result.
   function automatic logic signed [AccWidth-1:0] qterm(
      input logic [GainWidth-1:0]           gain,
      input logic signed [OperandWidth-1:0] operand
   );
      logic signed [GainWidth:0]       gain_s;
      logic signed [ProductWidth-1:0]  product;
      logic signed [ProductWidth-1:0]  shifted;
      gain_s  = $signed({1'b0, gain});
      product = gain_s * operand;
      shifted = product >>> QShift;
      return shifted[AccWidth-1:0];
   endfunction

endpackage

// File: rtl/pidpi_channels_if.sv
interface pidpi_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [pidpi_pkg::SampleWidth-1:0] setpoint;
   logic signed [pidpi_pkg::SampleWidth-1:0] measured;

   modport source (output valid, output setpoint, output measured, input ready);
   modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface pidpi_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [pidpi_pkg::DriveWidth-1:0] drive;
   logic                                    clamped;

   modport source (output valid, output drive, output clamped, input ready);
   modport sink   (input valid, input drive, input clamped, output ready);
endinterface

// File: rtl/pidpi_csr.sv
module pidpi_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [pidpi_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [pidpi_pkg::CsrDataWidth-1:0]  csr_wdata,
   output pidpi_pkg::cfg_type                 cfg
);
   import pidpi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN_P:         cfg_in.gain_p         = csr_wdata[GainWidth-1:0];
            CSR_GAIN_I:         cfg_in.gain_i         = csr_wdata[GainWidth-1:0];
            CSR_GAIN_D:         cfg_in.gain_d         = csr_wdata[GainWidth-1:0];
            CSR_DRIVE_MIN:      cfg_in.drive_min      = $signed(csr_wdata[DriveWidth-1:0]);
            CSR_DRIVE_MAX:      cfg_in.drive_max      = $signed(csr_wdata[DriveWidth-1:0]);
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[LimitWidth-1:0];
            CSR_LOOP_FORM:      cfg_in.loop_form      = csr_wdata[0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= GainPReset;
         cfg_ff.gain_i         <= GainIReset;
         cfg_ff.gain_d         <= GainDReset;
         cfg_ff.drive_min      <= DriveMinReset;
         cfg_ff.drive_max      <= DriveMaxReset;
         cfg_ff.integral_limit <= IntegLimReset;
         cfg_ff.loop_form      <= FORM_POSITIONAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/pidpi_loop.sv
module pidpi_loop (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pidpi_pkg::cfg_type                     cfg,
   input  logic signed [pidpi_pkg::ErrWidth-1:0]   err,
   input  logic                                   advance,
   output logic signed [pidpi_pkg::DriveWidth-1:0] drive_next,
   output logic                                   clamp_next
);
   import pidpi_pkg::*;

   logic signed [ErrWidth-1:0]   err_last_ff, err_last_in;
   logic signed [ErrWidth-1:0]   err_prev_ff, err_prev_in;
   logic signed [IntegWidth-1:0] integ_ff, integ_in;
   logic signed [DriveWidth-1:0] drive_ff;

   logic signed [ErrWidth:0]       diff1;
   logic signed [ErrWidth+1:0]     diff2;
   logic signed [IntegWidth-1:0]   limit_s;
   logic                           integ_inside;
   logic signed [OperandWidth-1:0] op_p, op_i, op_d;
   logic signed [OperandWidth-1:0] err_op;
   logic signed [AccWidth-1:0]     base, acc, above_val;
   logic signed [AccWidth-1:0]     max_ext, min_ext;
   logic                           above, below;
   logic                           incremental;

   assign incremental = (cfg.loop_form == FORM_INCREMENTAL);

   assign err_op = {{(OperandWidth-ErrWidth){err[ErrWidth-1]}}, err};
   assign diff1  = {err[ErrWidth-1], err} - {err_last_ff[ErrWidth-1], err_last_ff};
   assign diff2  = {{2{err[ErrWidth-1]}}, err}
                 - {err_last_ff[ErrWidth-1], err_last_ff, 1'b0}
                 + {{2{err_prev_ff[ErrWidth-1]}}, err_prev_ff};

   // The integral only moves in the positional form, and only while it sits strictly inside the window.
   assign limit_s      = $signed({2'b00, cfg.integral_limit});
   assign integ_inside = (integ_ff > -limit_s) && (integ_ff < limit_s);
   assign integ_in     = (!incremental && integ_inside) ? integ_ff + err_op : integ_ff;

   // Three shared multipliers; the form picks what each one sees.
   assign op_p = incremental ? OperandWidth'(diff1) : err_op;
   assign op_i = incremental ? err_op : integ_in;
   assign op_d = incremental ? OperandWidth'(diff2) : OperandWidth'(diff1);
   assign base = incremental ? AccWidth'(drive_ff) : '0;

   assign acc = base + qterm(cfg.gain_p, op_p) + qterm(cfg.gain_i, op_i)
              + qterm(cfg.gain_d, op_d);

   // Upper bound first, then lower, so the lower bound wins when inverted.
   assign max_ext   = AccWidth'(cfg.drive_max);
   assign min_ext   = AccWidth'(cfg.drive_min);
   assign above     = acc > max_ext;
   assign above_val = above ? max_ext : acc;
   assign below     = above_val < min_ext;

   assign drive_next = below ? cfg.drive_min : above_val[DriveWidth-1:0];
   assign clamp_next = above || below;

   assign err_last_in = err;
   assign err_prev_in = incremental ? err_last_ff : err_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_last_ff <= '0;
         err_prev_ff <= '0;
         integ_ff    <= '0;
         drive_ff    <= '0;
      end else if (advance) begin
         err_last_ff <= err_last_in;
         err_prev_ff <= err_prev_in;
         integ_ff    <= integ_in;
         drive_ff    <= drive_next;
      end
   end

endmodule

// File: rtl/pid_controller_pos_incr_core.sv
// An accepted word waits in the input register, then moves to the result register.
// Throughput: one word per cycle while the result side is ready; sample registers and
// the controller state all update in one step of the multiply, sum and clamp logic.
// The input register keeps taking words while a result waits, as long as
// the result register is freed in the same cycle.
// Reset (synchronous) clears all controller state and loads the register defaults.
module pid_controller_pos_incr_core (
   input  logic                               clock,
   input  logic                               reset,
   pidpi_req_if.sink                          req_chan,
   pidpi_rsp_if.source                        rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [pidpi_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [pidpi_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import pidpi_pkg::*;

   `include "pid_controller_pos_incr_core_assert.svh"

   cfg_type cfg;

   logic                         in_valid_ff, in_valid_in;
   logic signed [ErrWidth-1:0]   err_ff, err_in;
   logic                         out_valid_ff, out_valid_in;
   logic signed [DriveWidth-1:0] drive_out_ff;
   logic                         clamp_out_ff;

   logic                         advance;
   logic                         req_take;
   logic signed [DriveWidth-1:0] drive_next;
   logic                         clamp_next;

   pidpi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidpi_loop u_loop (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .err        (err_ff),
      .advance    (advance),
      .drive_next (drive_next),
      .clamp_next (clamp_next)
   );

   // A sample moves on when the result register is empty or being emptied.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   assign err_in = {req_chan.setpoint[SampleWidth-1], req_chan.setpoint}
                 - {req_chan.measured[SampleWidth-1], req_chan.measured};

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         err_ff <= err_in;
      end
      if (advance) begin
         drive_out_ff <= drive_next;
         clamp_out_ff <= clamp_next;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.drive   = drive_out_ff;
   assign rsp_chan.clamped = clamp_out_ff;

   `PIDPI_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_ff,
      "result register empty after a sample advanced")
   `PIDPI_ASSERT_NEXT(a_stalled_sample_holds, in_valid_ff && !advance,
      in_valid_ff && $stable(err_ff), "stalled sample was lost or changed")
   `PIDPI_ASSERT_NEXT(a_drive_above_min,
      advance && (cfg.drive_min <= cfg.drive_max),
      drive_out_ff >= $past(cfg.drive_min), "drive below lower limit")
   `PIDPI_ASSERT_NOW(a_no_take_when_full, in_valid_ff && out_valid_ff && !rsp_chan.ready,
      !req_chan.ready, "input accepted while both registers were held")

endmodule

// File: tb/tb.sv
module tb;
   import pidpi_pkg::*;

   typedef struct packed {
      logic signed [DriveWidth-1:0] drive;
      logic                         clamped;
   } drive_word_type;

   localparam longint CycleLimit   = 200000;
   localparam int     SettleCycles = 8;
   localparam int     RandomPhases = 8;
   localparam int     PhaseSamples = 170;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   pidpi_req_if req_bus ();
   pidpi_rsp_if rsp_bus ();

   pid_controller_pos_incr_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the controller: register settings and the loop state.
   cfg_type                      ctl_cfg;
   logic signed [ErrWidth-1:0]   err_last_q;
   logic signed [ErrWidth-1:0]   err_prev_q;
   logic signed [IntegWidth-1:0] integ_q;
   logic signed [DriveWidth-1:0] drive_q;

   drive_word_type drive_words_due[$];

   int     idle_pct;
   int     stall_pct;
   int     hold_off_left;
   int     mismatch_count;
   int     samples_sent;
   int     words_checked;
   int     clamp_hits;
   longint cycle_count = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb: run stopped after %0d cycles with %0d words outstanding",
                  cycle_count, drive_words_due.size());
         $display("tb: errors");
         $finish;
      end
   end

   // Result side: a long hold-off takes precedence over the random stalls.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < 40)
         $display("tb: mismatch on %s at word %0d: got %0d, want %0d",
                  what, words_checked, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : result_check
      drive_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (drive_words_due.size() == 0) begin
            report_mismatch("unrequested word", rsp_bus.drive, 0);
         end else begin
            want = drive_words_due.pop_front();
            if (rsp_bus.drive !== want.drive)
               report_mismatch("drive", rsp_bus.drive, want.drive);
            if (rsp_bus.clamped !== want.clamped)
               report_mismatch("clamped", rsp_bus.clamped, want.clamped);
            words_checked++;
         end
      end
   end

   // Product with a Q8.8 gain back to an integer; the arithmetic shift floors.
   function automatic longint q8_floor(input longint product);
      return product >>> QShift;
   endfunction

   function automatic drive_word_type advance_controller(
      input logic signed [SampleWidth-1:0] sp,
      input logic signed [SampleWidth-1:0] ms
   );
      longint         err_now;
      longint         err_last;
      longint         integ_next;
      longint         acc;
      longint         limit;
      drive_word_type word;
      err_now  = longint'(sp) - longint'(ms);
      err_last = longint'(err_last_q);
      limit    = longint'(ctl_cfg.integral_limit);
      if (ctl_cfg.loop_form == FORM_POSITIONAL) begin
         if (longint'(integ_q) > -limit && longint'(integ_q) < limit) begin
            integ_next = longint'(integ_q) + err_now;
            integ_q    = integ_next[IntegWidth-1:0];
         end
         acc = q8_floor(longint'(ctl_cfg.gain_p) * err_now)
             + q8_floor(longint'(ctl_cfg.gain_i) * longint'(integ_q))
             + q8_floor(longint'(ctl_cfg.gain_d) * (err_now - err_last));
      end else begin
         // The second difference of the error feeds the derivative term.
         acc = longint'(drive_q)
             + q8_floor(longint'(ctl_cfg.gain_i) * err_now)
             + q8_floor(longint'(ctl_cfg.gain_p) * (err_now - err_last))
             + q8_floor(longint'(ctl_cfg.gain_d) *
                        (err_now - 2 * err_last + longint'(err_prev_q)));
         err_prev_q = err_last_q;
      end
      err_last_q = err_now[ErrWidth-1:0];

      // The lower limit is applied last, so it wins when the limits cross.
      word.clamped = 1'b0;
      if (acc > longint'($signed(ctl_cfg.drive_max))) begin
         acc          = longint'($signed(ctl_cfg.drive_max));
         word.clamped = 1'b1;
      end
      if (acc < longint'($signed(ctl_cfg.drive_min))) begin
         acc          = longint'($signed(ctl_cfg.drive_min));
         word.clamped = 1'b1;
      end
      word.drive = acc[DriveWidth-1:0];
      drive_q    = word.drive;
      return word;
   endfunction

   task automatic send_sample(
      input logic signed [SampleWidth-1:0] sp,
      input logic signed [SampleWidth-1:0] ms
   );
      drive_word_type word;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.setpoint <= sp;
      req_bus.measured <= ms;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      word = advance_controller(sp, ms);
      drive_words_due.push_back(word);
      samples_sent++;
      if (word.clamped) clamp_hits++;
   endtask

   task automatic send_random_sample();
      logic [31:0]                   bits_a;
      logic [31:0]                   bits_b;
      logic signed [SampleWidth-1:0] sp;
      logic signed [SampleWidth-1:0] ms;
      bits_a = $urandom;
      bits_b = $urandom;
      sp     = bits_a[15:0];
      case ($urandom_range(4))
         0, 1: ms = bits_b[15:0];
         2: ms = sp + {{7{bits_b[8]}}, bits_b[8:0]};
         3: ms = sp + {{11{bits_b[4]}}, bits_b[4:0]};
         default: begin
            sp = bits_a[0] ? 16'sh7FFF : 16'sh8000;
            ms = bits_b[0] ? 16'sh7FFF : 16'sh8000;
         end
      endcase
      send_sample(sp, ms);
   endtask

   // Lowers valid, then waits until every pending word has been checked.
   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (drive_words_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(
      input logic [CsrIndexWidth-1:0] idx,
      input logic [CsrDataWidth-1:0]  data
   );
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_GAIN_P:         ctl_cfg.gain_p         = data[GainWidth-1:0];
         CSR_GAIN_I:         ctl_cfg.gain_i         = data[GainWidth-1:0];
         CSR_GAIN_D:         ctl_cfg.gain_d         = data[GainWidth-1:0];
         CSR_DRIVE_MIN:      ctl_cfg.drive_min      = data[DriveWidth-1:0];
         CSR_DRIVE_MAX:      ctl_cfg.drive_max      = data[DriveWidth-1:0];
         CSR_INTEGRAL_LIMIT: ctl_cfg.integral_limit = data[LimitWidth-1:0];
         CSR_LOOP_FORM:      ctl_cfg.loop_form      = data[0];
         default: ;
      endcase
   endtask

   task automatic write_all_regs(
      input logic [GainWidth-1:0]         gp,
      input logic [GainWidth-1:0]         gi,
      input logic [GainWidth-1:0]         gd,
      input logic signed [DriveWidth-1:0] lo,
      input logic signed [DriveWidth-1:0] hi,
      input logic [LimitWidth-1:0]        lim,
      input logic                         form
   );
      write_reg(CSR_GAIN_P, {8'h00, gp});
      write_reg(CSR_GAIN_I, {8'h00, gi});
      write_reg(CSR_GAIN_D, {8'h00, gd});
      write_reg(CSR_DRIVE_MIN, {8'h00, lo});
      write_reg(CSR_DRIVE_MAX, {8'h00, hi});
      write_reg(CSR_INTEGRAL_LIMIT, lim);
      write_reg(CSR_LOOP_FORM, {23'd0, form});
   endtask

   function automatic logic [GainWidth-1:0] pick_gain();
      logic [31:0] r;
      case ($urandom_range(5))
         0: r = 32'd0;
         1: r = 32'hFFFF;
         2, 3: r = $urandom_range(512);
         default: r = $urandom_range(4096);
      endcase
      return r[GainWidth-1:0];
   endfunction

   task automatic test_default_gains();
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      send_sample(-16'sd1, 16'sd0);
      send_sample(16'sd100, -16'sd100);
   endtask

   // The integral stops once it leaves the window, and a zero window freezes it.
   task automatic test_integral_window();
      wait_for_results();
      write_all_regs(16'd0, 16'd256, 16'd0, 16'sh8000, 16'sh7FFF, 24'd1000,
                     FORM_POSITIONAL);
      send_sample(16'sd600, 16'sd0);
      send_sample(16'sd600, 16'sd0);
      send_sample(16'sd600, 16'sd0);
      send_sample(16'sd0, 16'sd3000);
      wait_for_results();
      write_reg(CSR_INTEGRAL_LIMIT, 24'd0);
      send_sample(16'sd5, 16'sd0);
   endtask

   // Switching forms keeps the error history, the integral and the stored drive.
   task automatic test_incremental_form();
      wait_for_results();
      write_all_regs(16'd128, 16'd64, 16'd32, 16'sh8000, 16'sh7FFF, 24'd1048576,
                     FORM_INCREMENTAL);
      send_sample(16'sd1000, 16'sd0);
      send_sample(16'sd500, 16'sd200);
      send_sample(-16'sd700, 16'sd0);
      send_sample(16'sd0, 16'sd0);
      wait_for_results();
      write_reg(CSR_LOOP_FORM, {23'd0, FORM_POSITIONAL});
      send_sample(16'sd300, 16'sd0);
      wait_for_results();
      write_reg(CSR_LOOP_FORM, {23'd0, FORM_INCREMENTAL});
      send_sample(-16'sd300, 16'sd0);
   endtask

   task automatic test_drive_limits();
      wait_for_results();
      write_all_regs(16'd256, 16'd0, 16'd0, 16'sd100, -16'sd100, 24'd1048576,
                     FORM_POSITIONAL);
      send_sample(16'sd0, 16'sd0);
      send_sample(-16'sd500, 16'sd0);
      send_sample(16'sd500, 16'sd0);
      wait_for_results();
      write_reg(CSR_DRIVE_MIN, {8'h00, -16'sd50});
      write_reg(CSR_DRIVE_MAX, {8'h00, 16'sd50});
      send_sample(16'sd50, 16'sd0);
      send_sample(16'sd51, 16'sd0);
      send_sample(16'sd0, 16'sd50);
      send_sample(16'sd0, 16'sd51);
   endtask

   // The result side holds off while words keep coming, so the input stalls.
   task automatic test_backpressure();
      wait_for_results();
      idle_pct      = 0;
      stall_pct     = 0;
      hold_off_left = 80;
      repeat (40) send_random_sample();
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      logic [31:0]                  ra;
      logic [31:0]                  rb;
      logic [GainWidth-1:0]         gp;
      logic [GainWidth-1:0]         gi;
      logic [GainWidth-1:0]         gd;
      logic signed [DriveWidth-1:0] lo;
      logic signed [DriveWidth-1:0] hi;
      logic signed [DriveWidth-1:0] swap;
      logic [LimitWidth-1:0]        lim;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         wait_for_results();
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         gp = pick_gain();
         gi = pick_gain();
         gd = pick_gain();
         ra = $urandom;
         rb = $urandom;
         lo = ra[15:0];
         hi = rb[15:0];
         case ($urandom_range(3))
            0: begin lo = 16'sh8000; hi = 16'sh7FFF; end
            1: if (lo > hi) begin swap = lo; lo = hi; hi = swap; end
            2: if (lo < hi) begin swap = lo; lo = hi; hi = swap; end
            default: begin lo = -$signed({6'd0, ra[9:0]}); hi = {6'd0, rb[9:0]}; end
         endcase
         case ($urandom_range(3))
            0: lim = 24'd0;
            1: lim = 24'hFFFFFF;
            2: lim = {12'd0, ra[27:16]};
            default: lim = rb[23:0] ^ ra[31:8];
         endcase
         // The first phases pin the register extremes.
         if (phase == 0) begin
            gp = 16'd0; gi = 16'd0; gd = 16'd0; lim = 24'd0;
         end else if (phase == 1) begin
            gp = 16'hFFFF; gi = 16'hFFFF; gd = 16'hFFFF; lim = 24'hFFFFFF;
         end else if (phase == 2) begin
            lo = 16'sh7FFF; hi = 16'sh8000;
         end
         write_all_regs(gp, gi, gd, lo, hi, lim, phase[0]);
         repeat (PhaseSamples) send_random_sample();
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_GAIN_P;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.setpoint = '0;
      req_bus.measured = '0;
      rsp_bus.ready    = 1'b0;
      idle_pct         = 0;
      stall_pct        = 0;
      hold_off_left    = 0;
      mismatch_count   = 0;
      samples_sent     = 0;
      words_checked    = 0;
      clamp_hits       = 0;

      ctl_cfg.gain_p         = GainPReset;
      ctl_cfg.gain_i         = GainIReset;
      ctl_cfg.gain_d         = GainDReset;
      ctl_cfg.drive_min      = DriveMinReset;
      ctl_cfg.drive_max      = DriveMaxReset;
      ctl_cfg.integral_limit = IntegLimReset;
      ctl_cfg.loop_form      = FORM_POSITIONAL;
      err_last_q = '0;
      err_prev_q = '0;
      integ_q    = '0;
      drive_q    = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_gains();
      test_integral_window();
      test_incremental_form();
      test_drive_limits();
      test_backpressure();
      test_random_traffic();

      wait_for_results();
      repeat (SettleCycles) @(posedge clock);
      if (drive_words_due.size() != 0)
         report_mismatch("words never returned", drive_words_due.size(), 0);

      $display("tb: %0d samples through both loop forms and %0d register settings",
               samples_sent, RandomPhases + 4);
      $display("tb: %0d words checked, %0d at a drive limit, %0d mismatches",
               words_checked, clamp_hits, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
